@@ hw/rtl/id_allocator_with_free_stack_defines.svh @@
// Assertion macros shared by the identifier allocator RTL.
// Each macro expects the using module to have clk and an active-low rst_n.
`ifndef ID_ALLOCATOR_WITH_FREE_STACK_DEFINES_SVH
`define ID_ALLOCATOR_WITH_FREE_STACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDAL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDAL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/idal_pkg.sv @@
// Package for the identifier allocator: identifier width, function codes,
// status codes and the control structs passed between the top level and the engine.
`default_nettype none

package idal_pkg;

  localparam int ID_W = 8;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  typedef enum logic [2:0] {
    ST_ALLOCATED = 3'd0,
    ST_RELEASED  = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_EXHAUSTED = 3'd3,
    ST_FULL      = 3'd4
  } idal_status_t;

  // Command handed from the top level to the engine.
  typedef struct packed {
    logic            start;
    logic            func;
    logic [ID_W-1:0] id;
  } idal_cmd_t;

  // Engine status and result returned to the top level.
  typedef struct packed {
    logic            idle;
    logic            done;
    logic [ID_W-1:0] granted;
    idal_status_t    status;
  } idal_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/idal_in_if.sv @@
// Request channel of the identifier allocator: valid/ready plus request payload.
// No dependencies.
`default_nettype none

interface idal_in_if;
  logic       valid;
  logic       ready;
  logic       func;
  logic [7:0] release_id;

  modport source (output valid, output func, output release_id, input ready);
  modport sink   (input valid, input func, input release_id, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/idal_out_if.sv @@
// Result channel of the identifier allocator: valid/ready plus result payload.
// No dependencies.
`default_nettype none

interface idal_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] granted_id;
  logic [2:0] status;

  modport source (output valid, output granted_id, output status, input ready);
  modport sink   (input valid, input granted_id, input status, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/idal_free_ram.sv @@
// Free-list storage: one write port, one read port with registered read data.
// Depends on idal_pkg for the identifier width.
`default_nettype none

module idal_free_ram #(
  parameter int DEPTH = 256
) (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [$clog2(DEPTH)-1:0]   waddr,
  input  wire logic [idal_pkg::ID_W-1:0]  wdata,
  input  wire logic [$clog2(DEPTH)-1:0]   raddr,
  output logic      [idal_pkg::ID_W-1:0]  rdata
);
  import idal_pkg::*;

  logic [ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ hw/rtl/idal_engine.sv @@
// Allocation engine: sequencer, high-water mark, free count and the single
// compare unit that scans the free list, which the sequencer compacts. Depends on idal_pkg,
// idal_free_ram and the assertion macro header.
`default_nettype none
`include "id_allocator_with_free_stack_defines.svh"

module idal_engine #(
  parameter int MAX_IDS    = 256,
  parameter int FREE_DEPTH = 256
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire idal_pkg::idal_cmd_t cmd,
  input  wire logic                slot_free,
  output idal_pkg::idal_rsp_t      rsp
);
  import idal_pkg::*;

  localparam int NF_W  = $clog2(MAX_IDS + 1);
  localparam int CW    = $clog2(FREE_DEPTH + 1);
  localparam int AW    = $clog2(FREE_DEPTH);
  localparam int CMP_W = (NF_W > ID_W + 1) ? NF_W : ID_W + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_TOP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

  state_t          state_r,   state_nxt;
  logic [NF_W-1:0] nf_r,      nf_nxt;
  logic [CW-1:0]   cnt_r,     cnt_nxt;
  logic [CW-1:0]   k_r,       k_nxt;
  logic [ID_W-1:0] tgt_r,     tgt_nxt;
  logic [ID_W-1:0] granted_r, granted_nxt;
  idal_status_t    status_r,  status_nxt;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [ID_W-1:0] ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [ID_W-1:0] ram_rdata;

  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    k_p1;
  logic [CW-1:0]    k_p2;
  logic [ID_W-1:0]  tgt_m1;
  logic [CMP_W-1:0] id_p1;
  logic [CMP_W-1:0] nf_ext;
  logic             hit;

  idal_free_ram #(.DEPTH(FREE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cnt_m1 = cnt_r - CW'(1);
  assign k_p1   = k_r + CW'(1);
  assign k_p2   = k_r + CW'(2);
  assign tgt_m1 = tgt_r - ID_W'(1);
  assign id_p1  = CMP_W'(cmd.id) + CMP_W'(1);
  assign nf_ext = CMP_W'(nf_r);

  // The one compare unit: does the entry just read hold the identifier below the target?
  assign hit = (ram_rdata == tgt_m1);

  always_comb begin
    state_nxt   = state_r;
    nf_nxt      = nf_r;
    cnt_nxt     = cnt_r;
    k_nxt       = k_r;
    tgt_nxt     = tgt_r;
    granted_nxt = granted_r;
    status_nxt  = status_r;
    ram_we      = 1'b0;
    ram_waddr   = cnt_r[AW-1:0];
    ram_wdata   = cmd.id;
    ram_raddr   = k_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (cmd.start) begin
          granted_nxt = '0;
          if (cmd.func == FUNC_ALLOC) begin
            if (cnt_r != '0) begin
              ram_raddr = cnt_m1[AW-1:0];
              cnt_nxt   = cnt_m1;
              state_nxt = S_POP;
            end else if (nf_r < NF_W'(MAX_IDS)) begin
              granted_nxt = ID_W'(nf_r);
              nf_nxt      = nf_r + NF_W'(1);
              status_nxt  = ST_ALLOCATED;
              state_nxt   = S_DONE;
            end else begin
              status_nxt = ST_EXHAUSTED;
              state_nxt  = S_DONE;
            end
          end else begin
            if (id_p1 == nf_ext) begin
              tgt_nxt   = cmd.id;
              state_nxt = S_TOP;
            end else if (id_p1 < nf_ext) begin
              if (cnt_r == CW'(FREE_DEPTH)) begin
                status_nxt = ST_FULL;
              end else begin
                ram_we     = 1'b1;
                cnt_nxt    = cnt_r + CW'(1);
                status_nxt = ST_RELEASED;
              end
              state_nxt = S_DONE;
            end else begin
              status_nxt = ST_IGNORED;
              state_nxt  = S_DONE;
            end
          end
        end
      end

      S_POP: begin
        granted_nxt = ram_rdata;
        status_nxt  = ST_ALLOCATED;
        state_nxt   = S_DONE;
      end

      S_TOP: begin
        if (tgt_r == '0 || cnt_r == '0) begin
          nf_nxt     = NF_W'(tgt_r);
          status_nxt = ST_RELEASED;
          state_nxt  = S_DONE;
        end else begin
          k_nxt     = '0;
          ram_raddr = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (hit) begin
          if (k_p1 < cnt_r) begin
            ram_raddr = k_p1[AW-1:0];
            state_nxt = S_SHIFT;
          end else begin
            cnt_nxt   = cnt_m1;
            tgt_nxt   = tgt_m1;
            state_nxt = S_TOP;
          end
        end else if (k_p1 < cnt_r) begin
          k_nxt     = k_p1;
          ram_raddr = k_p1[AW-1:0];
        end else begin
          nf_nxt     = NF_W'(tgt_r);
          status_nxt = ST_RELEASED;
          state_nxt  = S_DONE;
        end
      end

      S_SHIFT: begin
        // Entry k+1 arrives now and moves down to slot k.
        ram_we    = 1'b1;
        ram_waddr = k_r[AW-1:0];
        ram_wdata = ram_rdata;
        k_nxt     = k_p1;
        if (k_p2 < cnt_r) begin
          ram_raddr = k_p2[AW-1:0];
        end else begin
          cnt_nxt   = cnt_m1;
          tgt_nxt   = tgt_m1;
          state_nxt = S_TOP;
        end
      end

      S_DONE: begin
        if (slot_free) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nf_r    <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      nf_r    <= nf_nxt;
      cnt_r   <= cnt_nxt;
    end
    k_r       <= k_nxt;
    tgt_r     <= tgt_nxt;
    granted_r <= granted_nxt;
    status_r  <= status_nxt;
  end

  assign rsp.idle    = (state_r == S_IDLE);
  assign rsp.done    = (state_r == S_DONE) && slot_free;
  assign rsp.granted = granted_r;
  assign rsp.status  = status_r;

  `IDAL_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(FREE_DEPTH), "free count above depth")
  `IDAL_ASSERT_IMPL(a_scan_in_list, state_r == S_SCAN, k_r < cnt_r, "scan index past list end")
  `IDAL_ASSERT_IMPL(a_shift_in_list, state_r == S_SHIFT, k_p1 < cnt_r, "shift source past list end")
  `IDAL_ASSERT_IMPL(a_start_idle, cmd.start, state_r == S_IDLE, "command taken while busy")
  `IDAL_ASSERT_NEXT(a_start_leaves, cmd.start, state_r != S_IDLE, "command did not start work")

endmodule

`default_nettype wire

@@ hw/rtl/id_allocator_with_free_stack.sv @@
// Top level of the identifier allocator: request/result channels, result register
// and the allocation engine. Depends on idal_pkg, idal_in_if, idal_out_if, idal_engine.
//
// Hands out small integer identifiers and takes them back. An allocate beat
// returns the most recently released identifier still in the free list, or,
// when the list is empty, the high-water mark (which then moves up); status
// reports allocated, released, release ignored, exhausted or free list full,
// and granted_id is zero unless an identifier was handed out. Releasing the
// identifier just below the mark lowers the mark and keeps lowering it while
// the next-lower identifier sits in the free list, removing each one found
// and closing the gap; a lower identifier is simply appended. The block works
// on one request beat at a time: in_ready is high only while the engine is
// idle. A release at the top is paced by the scan of the free list through
// its one read port: each search reads one entry per cycle and each removal
// shifts one entry per cycle, with one search per identifier absorbed into
// the mark plus at most one more. A finished result sits in an output
// register, so the next request beat is taken while that result still waits
// for out_ready. The free list memory needs no clearing after reset; only
// entries below the free count are read.
`default_nettype none

module id_allocator_with_free_stack #(
  parameter int MAX_IDS    = 256,
  parameter int FREE_DEPTH = 256
) (
  input wire logic   clk,
  input wire logic   rst_n,
  idal_in_if.sink    in_ch,
  idal_out_if.source out_ch
);
  import idal_pkg::*;

  idal_cmd_t       cmd;
  idal_rsp_t       rsp;
  logic            slot_free;

  logic            out_valid_r, out_valid_nxt;
  logic [ID_W-1:0] granted_r;
  idal_status_t    status_r;

  // The engine may only finish when the result register is empty or draining.
  assign slot_free = !out_valid_r || out_ch.ready;

  assign in_ch.ready = rsp.idle;
  assign cmd.start   = in_ch.valid && rsp.idle;
  assign cmd.func    = in_ch.func;
  assign cmd.id      = in_ch.release_id;

  idal_engine #(
    .MAX_IDS    (MAX_IDS),
    .FREE_DEPTH (FREE_DEPTH)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .slot_free (slot_free),
    .rsp       (rsp)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (rsp.done) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Result register: the valid flag is control state, the payload loads with each result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (rsp.done) begin
      granted_r <= rsp.granted;
      status_r  <= rsp.status;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.granted_id = granted_r;
  assign out_ch.status     = status_r;

endmodule

`default_nettype wire

@@ dv/tb_id_allocator_with_free_stack.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for id_allocator_with_free_stack: directed and random
// request beats, in-order checking of every result beat. Depends on idal_pkg,
// idal_in_if, idal_out_if and the RTL of the allocator.

module tb_id_allocator_with_free_stack;
  import idal_pkg::*;

  localparam int MAX_IDS    = 256;
  localparam int FREE_DEPTH = 256;
  // Print at most this many mismatch lines; all of them are counted.
  localparam int MAX_REPORTS = 50;
  // Roughly 1400 request beats in all, ignored releases included.
  localparam int WORK_BEATS = 1400;

  // How the stimulus picks the identifier of the next request beat.
  typedef enum int {
    K_ALLOC,   // allocate; the id field carries noise
    K_FIXED,   // release the given identifier
    K_TOP,     // release the identifier just below the mark
    K_BELOW,   // release an identifier below the mark minus one (appends)
    K_DUP,     // release an identifier already sitting in the free list
    K_ABOVE,   // release at or above the mark (ignored)
    K_ANY      // release a fully random identifier
  } req_kind_t;

  typedef struct packed {
    logic            func;
    logic [ID_W-1:0] id;
  } req_beat_t;

  typedef struct packed {
    logic [ID_W-1:0] grant;
    idal_status_t    status;
  } grant_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  idal_in_if  req_ch ();
  idal_out_if res_ch ();

  id_allocator_with_free_stack #(
    .MAX_IDS   (MAX_IDS),
    .FREE_DEPTH(FREE_DEPTH)
  ) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (req_ch),
    .out_ch(res_ch)
  );

  always #5 clk = ~clk;

  // Request beats waiting for the driver, and results owed by the block in order.
  req_beat_t req_backlog[$];
  grant_t    expected_grants[$];

  // The allocator as the testbench sees it: the high-water mark and the ordered
  // list of identifiers that were given back below it.
  int         id_mark;
  logic [7:0] freed_ids[$];

  // Set by the driver when it puts a beat on the bus, cleared when that beat is taken.
  bit req_held;
  int idle_pct;
  int stall_pct;
  int work_count;
  int mismatch_count;
  int cycle_count;
  // Grows with every accepted beat by several times the worst cost of that beat,
  // so a slow but correct run never trips it while a hang still does.
  int cycle_limit = 100000;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS)
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
  endtask

  // Removes the first copy of an identifier from the free list.
  function automatic bit take_freed(input int ident);
    for (int k = 0; k < freed_ids.size(); k++) begin
      if (int'(freed_ids[k]) == ident) begin
        freed_ids.delete(k);
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Applies one request beat to the tracked state and works out the result beat.
  // absorbed counts how many listed identifiers a top release folded into the mark.
  function automatic void serve_request(input logic func, input logic [7:0] ident,
                                        output grant_t res, output int absorbed);
    int top;
    res.grant = '0;
    absorbed  = 0;
    if (func == FUNC_ALLOC) begin
      if (freed_ids.size() > 0) begin
        // Most recently released identifier goes out first.
        res.grant  = freed_ids.pop_back();
        res.status = ST_ALLOCATED;
      end else if (id_mark < MAX_IDS) begin
        res.grant  = 8'(id_mark);
        id_mark++;
        res.status = ST_ALLOCATED;
      end else begin
        res.status = ST_EXHAUSTED;
      end
    end else if (int'(ident) + 1 == id_mark) begin
      // Top identifier: lower the mark, then keep sinking it through every
      // next-lower identifier found in the list. Zero never searches below itself.
      top = int'(ident);
      while (top > 0 && take_freed(top - 1)) begin
        top--;
        absorbed++;
      end
      id_mark    = top;
      res.status = ST_RELEASED;
    end else if (int'(ident) + 1 < id_mark) begin
      if (freed_ids.size() >= FREE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        // Double releases land here too: the identifier is simply listed again.
        freed_ids.insert(freed_ids.size(), ident);
        res.status = ST_RELEASED;
      end
    end else begin
      res.status = ST_IGNORED;
    end
  endfunction

  // Driver: one beat at a time from the backlog, with random sender gaps, and
  // random receiver stalls. Everything changes on the falling edge.
  always @(negedge clk) begin : drive
    req_beat_t beat;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= stall_pct);
      if (!req_held) begin
        if (req_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          beat = req_backlog.pop_front();
          req_ch.valid      <= 1'b1;
          req_ch.func       <= beat.func;
          req_ch.release_id <= beat.id;
          req_held = 1'b1;
        end else begin
          // Idle bus: payload wiggles so that nothing depends on it.
          req_ch.valid      <= 1'b0;
          req_ch.func       <= 1'($urandom);
          req_ch.release_id <= 8'($urandom);
        end
      end
    end
  end

  // Monitor: predicts on every accepted request beat and checks every accepted
  // result beat against the oldest expectation, on the rising edge.
  always @(posedge clk) begin : monitor
    grant_t want;
    int     listed;
    int     absorbed;
    if (rst_n) begin
      if (req_ch.valid && req_ch.ready) begin
        listed = freed_ids.size();
        serve_request(req_ch.func, req_ch.release_id, want, absorbed);
        expected_grants.insert(expected_grants.size(), want);
        // A top release scans the list once per absorbed identifier, plus one.
        cycle_limit += 4 * ((listed + 2) * (absorbed + 1) + 2 + 200);
        req_held = 1'b0;
      end
      if (res_ch.valid && res_ch.ready) begin
        if (expected_grants.size() == 0) begin
          report_mismatch($sformatf("result beat id=%0d status=%0d with nothing expected",
                                    res_ch.granted_id, res_ch.status));
        end else begin
          want = expected_grants.pop_front();
          if (res_ch.granted_id !== want.grant)
            report_mismatch($sformatf("granted_id %0d, expected %0d",
                                      res_ch.granted_id, want.grant));
          if (res_ch.status !== 3'(want.status))
            report_mismatch($sformatf("status %0d, expected %s",
                                      res_ch.status, want.status.name()));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > cycle_limit) begin
      $display("id_allocator_with_free_stack test failed");
      $finish;
    end
  end

  // Waits until every beat handed to the driver has been taken and predicted, so
  // the tracked state is current when the next beat is chosen.
  task automatic settle();
    while (req_backlog.size() != 0 || req_held) begin
      @(posedge clk);
      #1;
    end
  endtask

  // Waits until the block has also delivered every result owed.
  task automatic wait_drained();
    settle();
    while (expected_grants.size() != 0) begin
      @(posedge clk);
      #1;
    end
  endtask

  // Picks the identifier for one request beat from the current state and queues it.
  task automatic issue(input req_kind_t kind, input logic [7:0] field);
    logic       func;
    logic [7:0] ident;
    settle();
    func  = FUNC_RELEASE;
    ident = 8'($urandom);
    case (kind)
      K_ALLOC: begin
        func  = FUNC_ALLOC;
        ident = field;
      end
      K_FIXED: ident = field;
      K_TOP:   if (id_mark > 0) ident = 8'(id_mark - 1);
      K_BELOW: if (id_mark >= 2) ident = 8'($urandom_range(id_mark - 2));
      K_DUP:   if (freed_ids.size() > 0) ident = freed_ids[$urandom_range(freed_ids.size() - 1)];
      K_ABOVE: if (id_mark <= 255) ident = 8'($urandom_range(255, id_mark));
      default: ;
    endcase
    work_count++;
    req_backlog.insert(req_backlog.size(), req_beat_t'{func: func, id: ident});
  endtask

  // Mixed traffic around the current mark.
  task automatic churn(input int beats);
    int pick;
    repeat (beats) begin
      pick = $urandom_range(99);
      if (pick < 40)      issue(K_ALLOC, 8'($urandom));
      else if (pick < 55) issue(K_TOP, 8'd0);
      else if (pick < 75) issue(K_BELOW, 8'd0);
      else if (pick < 82) issue(K_DUP, 8'd0);
      else if (pick < 92) issue(K_ANY, 8'd0);
      else                issue(K_ABOVE, 8'd0);
    end
  endtask

  // Pulls the mark down to a small value by top releases mixed with appends.
  task automatic sink_mark();
    int floor_id;
    floor_id = $urandom_range(8);
    settle();
    while (id_mark > floor_id) begin
      if ($urandom_range(3) != 0) issue(K_TOP, 8'd0);
      else                        issue(K_BELOW, 8'd0);
      settle();
    end
  endtask

  // Raises the mark, then gives every identifier back in shuffled order and
  // finally the top one, so one release folds a long chain into the mark.
  task automatic ramp_and_return();
    int ids[$];
    int span;
    int j;
    int tmp;
    span = ($urandom_range(9) == 0) ? $urandom_range(120, 40) : $urandom_range(30, 1);
    repeat (span) issue(K_ALLOC, 8'($urandom));
    churn($urandom_range(30, 5));
    settle();
    for (int i = 0; i + 1 < id_mark; i++) ids.insert(ids.size(), i);
    for (int i = ids.size() - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = ids[i];
      ids[i] = ids[j];
      ids[j] = tmp;
    end
    foreach (ids[i]) issue(K_FIXED, 8'(ids[i]));
    issue(K_TOP, 8'd0);
  endtask

  initial begin : stimulus
    int round;
    req_ch.valid      = 1'b0;
    req_ch.func       = FUNC_ALLOC;
    req_ch.release_id = '0;
    res_ch.ready      = 1'b0;
    idle_pct  = 0;
    stall_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed opening. Releases with nothing handed out are ignored, at both ends
    // of the id range; identifier zero at the top drops the mark to zero.
    issue(K_FIXED, 8'd0);
    issue(K_FIXED, 8'd255);
    issue(K_ALLOC, 8'd255);
    issue(K_FIXED, 8'd0);
    repeat (4) issue(K_ALLOC, 8'd0);
    // Identifier 1 is given back twice, then 0 and 2 are listed; releasing 3 then
    // folds 2, 1 and 0 into the mark and leaves the stale second copy of 1 behind.
    issue(K_FIXED, 8'd1);
    issue(K_FIXED, 8'd1);
    issue(K_FIXED, 8'd0);
    issue(K_FIXED, 8'd2);
    issue(K_FIXED, 8'd3);
    // The stale copy goes out first, then fresh identifiers again.
    issue(K_ALLOC, 8'hAA);
    issue(K_ALLOC, 8'h55);
    issue(K_ALLOC, 8'h0F);
    issue(K_FIXED, 8'd255);
    issue(K_FIXED, 8'd200);
    // Top release with an empty list, then zero at the top once more.
    issue(K_FIXED, 8'd1);
    issue(K_FIXED, 8'd0);

    round = 0;
    while (work_count < WORK_BEATS) begin
      // Idling rotates per round: none, sender gaps, receiver stalls, both.
      case (round % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 51; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 51; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      // Now and then the sender holds off until every result is back.
      if (round == 1 || $urandom_range(3) == 0)
        wait_drained();

      if (round == 2) begin
        // Hand out every identifier, then allocate past the end.
        settle();
        while (!(id_mark == MAX_IDS && freed_ids.size() == 0)) begin
          issue(K_ALLOC, 8'($urandom));
          settle();
        end
        repeat (3) issue(K_ALLOC, 8'($urandom));
        issue(K_FIXED, 8'd255);
        issue(K_ABOVE, 8'd0);
        churn($urandom_range(40, 20));
      end else if (round == 5) begin
        // Fill the free list to the brim and push further releases against it.
        settle();
        while (id_mark < 8) begin
          issue(K_ALLOC, 8'($urandom));
          settle();
        end
        while (freed_ids.size() < FREE_DEPTH) begin
          issue(K_BELOW, 8'd0);
          settle();
        end
        repeat (3) issue(K_BELOW, 8'd0);
        issue(K_ABOVE, 8'd0);
        repeat (2) issue(K_ALLOC, 8'($urandom));
        repeat (3) issue(K_BELOW, 8'd0);
        // A top release against a full list scans it until the next-lower identifier is found.
        issue(K_TOP, 8'd0);
        settle();
        while (freed_ids.size() > 16) begin
          if ($urandom_range(9) == 0) issue(K_TOP, 8'd0);
          else                        issue(K_ALLOC, 8'($urandom));
          settle();
        end
      end else begin
        case ($urandom_range(9))
          6, 7, 8: ramp_and_return();
          9:       sink_mark();
          default: churn($urandom_range(60, 20));
        endcase
      end
      round++;
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (expected_grants.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_grants.size()));
    if (mismatch_count == 0) begin
      $display("id_allocator_with_free_stack test passed");
    end else begin
      $display("id_allocator_with_free_stack test failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/idal_pkg.sv
hw/rtl/idal_in_if.sv
hw/rtl/idal_out_if.sv
hw/rtl/idal_free_ram.sv
hw/rtl/idal_engine.sv
hw/rtl/id_allocator_with_free_stack.sv
dv/tb_id_allocator_with_free_stack.sv
